### rtl/core/cpm_pkg.sv
// Shared types and constants for the padded 2D convolution MAC core.
// No dependencies.
package cpm_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_BIAS   = 2'd1,
        OP_LOAD_SAMPLE = 2'd2,
        OP_COMPUTE     = 2'd3
    } op_t;

    localparam int BATCH_TAG_W = 4;
    localparam int OCH_TAG_W   = 6;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = 32;
    localparam int DATA_W      = 16;

    typedef struct packed {
        logic                   first_elem;
        logic                   last_elem;
        logic                   last_run;
        logic                   in_image;
        logic [BATCH_TAG_W-1:0] batch;
        logic [OCH_TAG_W-1:0]   och;
    } mac_tag_t;

endpackage

### rtl/core/cpm_mac_unit.sv
// Multiply and accumulate stage of the convolution core.
// Depends on cpm_pkg.
module cpm_mac_unit
    import cpm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  mac_tag_t                 in_tag,
    input  logic signed [DATA_W-1:0] weight,
    input  logic signed [DATA_W-1:0] sample,
    input  logic signed [DATA_W-1:0] bias,
    output logic                     res_valid,
    output mac_tag_t                 res_tag,
    output logic signed [ACC_W-1:0]  res_value
);

    logic                     p_valid_reg;
    mac_tag_t                 p_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] bias_p_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_tag_reg  <= in_tag;
            bias_p_reg <= bias;
            prod_reg   <= in_tag.in_image ? PROD_W'(weight * sample) : '0;
        end
    end

    assign acc_base = p_tag_reg.first_elem ? (ACC_W'(bias_p_reg) <<< 8) : acc_reg;
    assign acc_next = acc_base + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (adv && p_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign res_valid = p_valid_reg && p_tag_reg.last_elem;
    assign res_tag   = p_tag_reg;
    assign res_value = acc_next;

endmodule

### rtl/core/conv2d_padded_mac_core.sv
// Batched direct 2D convolution core with zero padding, Q8.8 in, Q24.16 out.
// Depends on cpm_pkg and cpm_mac_unit.
//
// Load transactions (weight, bias, sample) are written straight into memory. A
// compute transaction issues one multiply-accumulate per cycle through the
// single image memory read port while the result side does not stall:
// BATCH_COUNT*OUT_CHANNEL_COUNT*IN_CHANNEL_COUNT*KERNEL_DIM*KERNEL_DIM of them
// (3072 by default). Results come out in batch-major, output-channel-minor
// order; the final one carries tlast. Positions beyond the padded output size
// give no results.
module conv2d_padded_mac_core
    import cpm_pkg::*;
#(
    parameter int BATCH_COUNT       = 4,
    parameter int IN_CHANNEL_COUNT  = 3,
    parameter int OUT_CHANNEL_COUNT = 16,
    parameter int KERNEL_DIM        = 4,
    parameter int IMAGE_HEIGHT      = 64,
    parameter int IMAGE_WIDTH       = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,      // pad_amount
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,          // batch_index, out_channel_index,
                                          // in_channel_index, row_index,
                                          // col_index, data_value
    input  logic [1:0]  s_tuser,          // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,          // out_batch, result channel, conv_result
    output logic        m_tlast           // last_of_run
);

    localparam int BW  = (BATCH_COUNT > 1) ? $clog2(BATCH_COUNT) : 1;
    localparam int OW  = (OUT_CHANNEL_COUNT > 1) ? $clog2(OUT_CHANNEL_COUNT) : 1;
    localparam int IW  = (IN_CHANNEL_COUNT > 1) ? $clog2(IN_CHANNEL_COUNT) : 1;
    localparam int KW  = (KERNEL_DIM > 1) ? $clog2(KERNEL_DIM) : 1;
    localparam int WDEPTH = OUT_CHANNEL_COUNT * IN_CHANNEL_COUNT * KERNEL_DIM * KERNEL_DIM;
    localparam int IDEPTH = BATCH_COUNT * IN_CHANNEL_COUNT * IMAGE_HEIGHT * IMAGE_WIDTH;
    localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int IAW = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
    localparam int CW  = 12;

    logic signed [DATA_W-1:0] weight_mem [WDEPTH];
    logic signed [DATA_W-1:0] bias_mem   [OUT_CHANNEL_COUNT];
    logic signed [DATA_W-1:0] image_mem  [IDEPTH];

    op_t                      in_op;
    logic [1:0]               in_batch;
    logic [3:0]               in_och;
    logic [1:0]               in_ich;
    logic [5:0]               in_row;
    logic [5:0]               in_col;
    logic signed [DATA_W-1:0] in_data;

    logic        s_acc;
    logic        adv;
    logic [1:0]  pad_reg;
    logic        busy_reg;
    logic        iss_reg;
    logic [5:0]  row_reg;
    logic [5:0]  col_reg;
    logic [BW-1:0]  b_reg;
    logic [OW-1:0]  o_reg;
    logic [IW-1:0]  i_reg;
    logic [KW-1:0]  kr_reg;
    logic [KW-1:0]  kc_reg;
    logic [WAW-1:0] waddr_reg;

    logic signed [CW-1:0] lim_h;
    logic signed [CW-1:0] lim_w;
    logic                 pos_ok;
    logic signed [CW-1:0] img_r;
    logic signed [CW-1:0] img_c;
    logic                 in_image;
    logic [IAW-1:0]       iaddr;
    logic                 end_kc, end_kr, end_i, end_o, end_b;
    mac_tag_t             iss_tag;

    logic                     s1_valid_reg;
    mac_tag_t                 s1_tag_reg;
    logic signed [DATA_W-1:0] w_rd_reg;
    logic signed [DATA_W-1:0] s_rd_reg;
    logic signed [DATA_W-1:0] b_rd_reg;

    logic                    res_valid;
    mac_tag_t                res_tag;
    logic signed [ACC_W-1:0] res_value;

    logic              m_valid_reg;
    logic              m_last_reg;
    logic [1:0]        m_batch_reg;
    logic [3:0]        m_och_reg;
    logic [ACC_W-1:0]  m_value_reg;

    assign in_op    = op_t'(s_tuser);
    assign in_batch = s_tdata[1:0];
    assign in_och   = s_tdata[5:2];
    assign in_ich   = s_tdata[7:6];
    assign in_row   = s_tdata[13:8];
    assign in_col   = s_tdata[19:14];
    assign in_data  = s_tdata[35:20];

    assign s_tready = !busy_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign adv      = !(m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_reg <= 2'd1;
        end else if (cfg_wr_en) begin
            pad_reg <= cfg_wr_data;
        end
    end

    // loads
    always_ff @(posedge aclk) begin
        if (s_acc && in_op == OP_LOAD_WEIGHT && 32'(in_och) < OUT_CHANNEL_COUNT
                && 32'(in_ich) < IN_CHANNEL_COUNT && 32'(in_row) < KERNEL_DIM
                && 32'(in_col) < KERNEL_DIM) begin
            weight_mem[WAW'(((32'(in_och) * IN_CHANNEL_COUNT + 32'(in_ich)) * KERNEL_DIM
                + 32'(in_row)) * KERNEL_DIM + 32'(in_col))] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && in_op == OP_LOAD_BIAS && 32'(in_och) < OUT_CHANNEL_COUNT) begin
            bias_mem[OW'(in_och)] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && in_op == OP_LOAD_SAMPLE && 32'(in_batch) < BATCH_COUNT
                && 32'(in_ich) < IN_CHANNEL_COUNT && 32'(in_row) < IMAGE_HEIGHT
                && 32'(in_col) < IMAGE_WIDTH) begin
            image_mem[IAW'(((32'(in_batch) * IN_CHANNEL_COUNT + 32'(in_ich)) * IMAGE_HEIGHT
                + 32'(in_row)) * IMAGE_WIDTH + 32'(in_col))] <= in_data;
        end
    end

    assign lim_h  = CW'(IMAGE_HEIGHT - KERNEL_DIM + 1) + (CW'(pad_reg) <<< 1);
    assign lim_w  = CW'(IMAGE_WIDTH - KERNEL_DIM + 1) + (CW'(pad_reg) <<< 1);
    assign pos_ok = ($signed(CW'(in_row)) < lim_h) && ($signed(CW'(in_col)) < lim_w);

    assign img_r  = $signed(CW'(row_reg)) + $signed(CW'(kr_reg)) - $signed(CW'(pad_reg));
    assign img_c  = $signed(CW'(col_reg)) + $signed(CW'(kc_reg)) - $signed(CW'(pad_reg));
    assign in_image = (img_r >= 0) && (img_r < CW'(IMAGE_HEIGHT))
                   && (img_c >= 0) && (img_c < CW'(IMAGE_WIDTH));
    assign iaddr  = IAW'(((32'(b_reg) * IN_CHANNEL_COUNT + 32'(i_reg)) * IMAGE_HEIGHT
                  + 32'(img_r[CW-2:0])) * IMAGE_WIDTH + 32'(img_c[CW-2:0]));

    assign end_kc = 32'(kc_reg) == KERNEL_DIM - 1;
    assign end_kr = 32'(kr_reg) == KERNEL_DIM - 1;
    assign end_i  = 32'(i_reg) == IN_CHANNEL_COUNT - 1;
    assign end_o  = 32'(o_reg) == OUT_CHANNEL_COUNT - 1;
    assign end_b  = 32'(b_reg) == BATCH_COUNT - 1;

    always_comb begin
        iss_tag.first_elem = (i_reg == '0) && (kr_reg == '0) && (kc_reg == '0);
        iss_tag.last_elem  = end_kc && end_kr && end_i;
        iss_tag.last_run   = end_kc && end_kr && end_i && end_o && end_b;
        iss_tag.in_image   = in_image;
        iss_tag.batch      = BATCH_TAG_W'(b_reg);
        iss_tag.och        = OCH_TAG_W'(o_reg);
    end

    // issue sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iss_reg  <= 1'b0;
        end else begin
            if (s_acc && in_op == OP_COMPUTE && pos_ok) begin
                busy_reg <= 1'b1;
                iss_reg  <= 1'b1;
            end else begin
                if (adv && iss_reg && iss_tag.last_run) begin
                    iss_reg <= 1'b0;
                end
                if (adv && res_valid && res_tag.last_run) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            row_reg   <= in_row;
            col_reg   <= in_col;
            b_reg     <= '0;
            o_reg     <= '0;
            i_reg     <= '0;
            kr_reg    <= '0;
            kc_reg    <= '0;
            waddr_reg <= '0;
        end else if (adv && iss_reg) begin
            kc_reg <= end_kc ? '0 : kc_reg + 1'b1;
            if (end_kc) begin
                kr_reg <= end_kr ? '0 : kr_reg + 1'b1;
                if (end_kr) begin
                    i_reg <= end_i ? '0 : i_reg + 1'b1;
                    if (end_i) begin
                        o_reg <= end_o ? '0 : o_reg + 1'b1;
                        if (end_o) begin
                            b_reg <= end_b ? '0 : b_reg + 1'b1;
                        end
                    end
                end
            end
            waddr_reg <= (iss_tag.last_elem && end_o) ? '0 : waddr_reg + 1'b1;
        end
    end

    // synchronous reads into registers
    always_ff @(posedge aclk) begin
        if (adv && iss_reg) begin
            w_rd_reg <= weight_mem[waddr_reg];
            s_rd_reg <= image_mem[iaddr];
            b_rd_reg <= bias_mem[o_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= iss_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= iss_tag;
        end
    end

    cpm_mac_unit u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .in_tag    (s1_tag_reg),
        .weight    (w_rd_reg),
        .sample    (s_rd_reg),
        .bias      (b_rd_reg),
        .res_valid (res_valid),
        .res_tag   (res_tag),
        .res_value (res_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res_valid) begin
            m_last_reg  <= res_tag.last_run;
            m_batch_reg <= res_tag.batch[1:0];
            m_och_reg   <= res_tag.och[3:0];
            m_value_reg <= res_value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_value_reg, m_och_reg, m_batch_reg};

`ifndef NO_ASSERTIONS
    a_busy_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> m_valid_reg && m_last_reg)
        else $error("run ended without a final result");
    a_idle_no_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !iss_reg && !s1_valid_reg)
        else $error("accepting while still issuing");
    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> !s1_valid_reg)
        else $error("issue continued past the final result");
`endif

endmodule
